>>> sv/pafc_pkg.sv
// Shared types, codes and constants for the pixel alpha format converter.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package pafc_pkg;

    // Field widths
    localparam int CH_W   = 16;
    localparam int BYTE_W = 8;
    localparam int WORD_W = 32;
    localparam int EXT_W  = 40;

    // 1.0 in channel fixed point
    localparam logic [CH_W-1:0] FULL_SCALE = 16'hFFFF;

    // Byte narrowing divisor: 65535 squared
    localparam logic [EXT_W-1:0] NARROW_DEN = 40'd4294836225;

    // Register stages inside each lane (the top adds one output register)
    localparam int LANE_DEPTH = 6;

    // Alpha handling codes (code 3 behaves as straight alpha)
    localparam logic [1:0] MODE_PREMUL = 2'd0;
    localparam logic [1:0] MODE_OPAQUE = 2'd2;

    // Operation codes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Register indexes
    localparam logic REG_BYTE_ORDER     = 1'b0;
    localparam logic REG_ALPHA_HANDLING = 1'b1;

    // Configuration seen by both lanes
    typedef struct packed {
        logic       byte_order;
        logic [1:0] alpha_handling;
    } t_cfg;

    // Widen a byte to channel scale (byte * 257)
    function automatic logic [CH_W-1:0] widen_byte(input logic [BYTE_W-1:0] b);
        return {b, b};
    endfunction

endpackage

>>> sv/pafc_rd_lane.sv
// Read lane: unpacks a pixel word and un-premultiplies colors with a
// pipelined restoring divider. Depends on pafc_pkg.
`timescale 1ns / 1ps

module pafc_rd_lane
    import pafc_pkg::*;
(
    input  logic              i_clk,
    input  t_cfg              i_cfg,
    input  logic [WORD_W-1:0] i_pixel_word,
    output logic [CH_W-1:0]   o_red,
    output logic [CH_W-1:0]   o_green,
    output logic [CH_W-1:0]   o_blue,
    output logic [CH_W-1:0]   o_alpha
);

    localparam int NCH        = 3;
    localparam int DIV_STAGES = 4;
    localparam int STEPS      = CH_W / DIV_STAGES;

    // Stage 0 holds the unpacked bytes, stages 1..4 the divider progress
    logic [BYTE_W-1:0] r_c8  [0:DIV_STAGES][NCH];
    logic [BYTE_W-1:0] r_a8  [0:DIV_STAGES];
    logic [BYTE_W-1:0] r_rem [0:DIV_STAGES][NCH];
    logic [CH_W-1:0]   r_dq  [0:DIV_STAGES][NCH];

    logic [BYTE_W-1:0] n_c8  [NCH];
    logic [BYTE_W-1:0] n_rem [NCH];
    logic [CH_W-1:0]   n_dq  [NCH];

    logic [CH_W-1:0]   r_red, r_green, r_blue, r_alpha;
    logic [CH_W-1:0]   n_chan [NCH];
    logic [CH_W-1:0]   n_alpha;

    // Pick bytes by order and form the dividend byte * 65535
    always_comb begin
        logic [BYTE_W+CH_W-1:0] num;
        n_c8[0] = i_cfg.byte_order ? i_pixel_word[23:16] : i_pixel_word[7:0];
        n_c8[1] = i_pixel_word[15:8];
        n_c8[2] = i_cfg.byte_order ? i_pixel_word[7:0] : i_pixel_word[23:16];
        for (int ch = 0; ch < NCH; ch++) begin
            num = {n_c8[ch], {CH_W{1'b0}}} - {{CH_W{1'b0}}, n_c8[ch]};
            n_rem[ch] = num[BYTE_W+CH_W-1:CH_W];
            n_dq[ch]  = num[CH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_a8[0] <= i_pixel_word[31:24];
        for (int ch = 0; ch < NCH; ch++) begin
            r_c8[0][ch]  <= n_c8[ch];
            r_rem[0][ch] <= n_rem[ch];
            r_dq[0][ch]  <= n_dq[ch];
        end
    end

    // Divider stages: four quotient bits per stage
    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
        logic [BYTE_W-1:0] s_rem [NCH];
        logic [CH_W-1:0]   s_dq  [NCH];

        always_comb begin
            logic [BYTE_W:0] trial;
            logic            qbit;
            for (int ch = 0; ch < NCH; ch++) begin
                s_rem[ch] = r_rem[j][ch];
                s_dq[ch]  = r_dq[j][ch];
                for (int t = 0; t < STEPS; t++) begin
                    trial = {s_rem[ch], s_dq[ch][CH_W-1]};
                    qbit  = (trial >= {1'b0, r_a8[j]});
                    if (qbit) begin
                        trial = trial - {1'b0, r_a8[j]};
                    end
                    s_rem[ch] = trial[BYTE_W-1:0];
                    s_dq[ch]  = {s_dq[ch][CH_W-2:0], qbit};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_a8[j+1] <= r_a8[j];
            for (int ch = 0; ch < NCH; ch++) begin
                r_c8[j+1][ch]  <= r_c8[j][ch];
                r_rem[j+1][ch] <= s_rem[ch];
                r_dq[j+1][ch]  <= s_dq[ch];
            end
        end
    end

    // Saturate, bypass on zero alpha or outside premultiplied mode, and pick alpha
    always_comb begin
        for (int ch = 0; ch < NCH; ch++) begin
            if (i_cfg.alpha_handling == MODE_PREMUL && r_a8[DIV_STAGES] != '0) begin
                n_chan[ch] = (r_c8[DIV_STAGES][ch] >= r_a8[DIV_STAGES])
                           ? FULL_SCALE : r_dq[DIV_STAGES][ch];
            end else begin
                n_chan[ch] = widen_byte(r_c8[DIV_STAGES][ch]);
            end
        end
        n_alpha = (i_cfg.alpha_handling == MODE_OPAQUE)
                ? FULL_SCALE : widen_byte(r_a8[DIV_STAGES]);
    end

    always_ff @(posedge i_clk) begin
        r_red   <= n_chan[0];
        r_green <= n_chan[1];
        r_blue  <= n_chan[2];
        r_alpha <= n_alpha;
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;
    assign o_alpha = r_alpha;

endmodule

>>> sv/pafc_wr_lane.sv
// Write lane: optional alpha multiply, narrowing to bytes by a pipelined
// restoring divide by 65535 squared, and packing. Depends on pafc_pkg.
`timescale 1ns / 1ps

module pafc_wr_lane
    import pafc_pkg::*;
(
    input  logic              i_clk,
    input  t_cfg              i_cfg,
    input  logic [CH_W-1:0]   i_red,
    input  logic [CH_W-1:0]   i_green,
    input  logic [CH_W-1:0]   i_blue,
    input  logic [CH_W-1:0]   i_alpha,
    output logic [WORD_W-1:0] o_packed
);

    localparam int NCH        = 4;
    localparam int DIV_STAGES = 4;
    localparam int STEPS      = BYTE_W / DIV_STAGES;
    localparam int PROD_W     = 2 * CH_W;

    logic [PROD_W-1:0] r_prod [NCH];
    logic [EXT_W-1:0]  r_rem  [0:DIV_STAGES][NCH];
    logic [BYTE_W-1:0] r_q    [0:DIV_STAGES][NCH];

    logic [CH_W-1:0]   n_chan [NCH];
    logic [CH_W-1:0]   n_mult [NCH];

    // Scale colors by alpha in premultiplied mode, else by 1.0
    always_comb begin
        n_chan[0] = i_red;
        n_chan[1] = i_green;
        n_chan[2] = i_blue;
        n_chan[3] = i_alpha;
        for (int ch = 0; ch < NCH - 1; ch++) begin
            n_mult[ch] = (i_cfg.alpha_handling == MODE_PREMUL) ? i_alpha : FULL_SCALE;
        end
        n_mult[NCH-1] = FULL_SCALE;
    end

    always_ff @(posedge i_clk) begin
        for (int ch = 0; ch < NCH; ch++) begin
            r_prod[ch] <= {{CH_W{1'b0}}, n_chan[ch]} * {{CH_W{1'b0}}, n_mult[ch]};
        end
    end

    // Times 255 as shift and subtract
    always_ff @(posedge i_clk) begin
        for (int ch = 0; ch < NCH; ch++) begin
            r_rem[0][ch] <= {r_prod[ch], {BYTE_W{1'b0}}} - {{BYTE_W{1'b0}}, r_prod[ch]};
            r_q[0][ch]   <= '0;
        end
    end

    // Divider stages: two quotient bits per stage, high bit first
    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
        logic [EXT_W-1:0]  s_rem [NCH];
        logic [BYTE_W-1:0] s_q   [NCH];

        always_comb begin
            logic [EXT_W-1:0] sub;
            logic             qbit;
            for (int ch = 0; ch < NCH; ch++) begin
                s_rem[ch] = r_rem[j][ch];
                s_q[ch]   = r_q[j][ch];
                for (int t = 0; t < STEPS; t++) begin
                    sub  = NARROW_DEN << (BYTE_W - 1 - STEPS * j - t);
                    qbit = (s_rem[ch] >= sub);
                    if (qbit) begin
                        s_rem[ch] = s_rem[ch] - sub;
                    end
                    s_q[ch] = {s_q[ch][BYTE_W-2:0], qbit};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            for (int ch = 0; ch < NCH; ch++) begin
                r_rem[j+1][ch] <= s_rem[ch];
                r_q[j+1][ch]   <= s_q[ch];
            end
        end
    end

    // Pack bytes in configured order; opaque mode drops alpha
    always_comb begin
        logic [BYTE_W-1:0] first, third, abyte;
        first = i_cfg.byte_order ? r_q[DIV_STAGES][2] : r_q[DIV_STAGES][0];
        third = i_cfg.byte_order ? r_q[DIV_STAGES][0] : r_q[DIV_STAGES][2];
        abyte = (i_cfg.alpha_handling == MODE_OPAQUE) ? '0 : r_q[DIV_STAGES][3];
        o_packed = {abyte, third, r_q[DIV_STAGES][1], first};
    end

endmodule

>>> sv/pixel_alpha_format_converter_core.sv
// Top level of the pixel alpha format converter: config port, item
// pipeline control and output registers. Depends on pafc_pkg and both lanes.
// Each item passes the six register stages in each lane, its valid bit alongside,
// and then the result register that drives o_valid.
// Throughput: one item per cycle, busy never asserts; results cannot be held off.
// Synchronous active-low reset clears the config registers and the valid pipeline.
`timescale 1ns / 1ps

module pixel_alpha_format_converter_core
    import pafc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Item command
    input  logic              start,
    output logic              busy,
    input  logic              i_operation,
    input  logic [WORD_W-1:0] i_pixel_word,
    input  logic [CH_W-1:0]   i_red_in,
    input  logic [CH_W-1:0]   i_green_in,
    input  logic [CH_W-1:0]   i_blue_in,
    input  logic [CH_W-1:0]   i_alpha_in,
    // Results
    output logic              o_valid,
    output logic [WORD_W-1:0] o_packed_out,
    output logic [CH_W-1:0]   o_red_out,
    output logic [CH_W-1:0]   o_green_out,
    output logic [CH_W-1:0]   o_blue_out,
    output logic [CH_W-1:0]   o_alpha_out,
    // Config port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic cfg_wr;
    logic reg_idx;

    logic [LANE_DEPTH-1:0] r_vld, n_vld;
    logic [LANE_DEPTH-1:0] r_op,  n_op;

    logic              r_valid;
    logic [WORD_W-1:0] r_packed;
    logic [CH_W-1:0]   r_red, r_green, r_blue, r_alpha;

    logic [WORD_W-1:0] wr_packed;
    logic [CH_W-1:0]   rd_red, rd_green, rd_blue, rd_alpha;
    logic              last_rd;

    // Config registers
    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign reg_idx = paddr[2];

    always_comb begin
        n_cfg = r_cfg;
        if (cfg_wr) begin
            unique case (reg_idx)
                REG_BYTE_ORDER:     n_cfg.byte_order     = pwdata[0];
                REG_ALPHA_HANDLING: n_cfg.alpha_handling = pwdata[1:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_BYTE_ORDER:     prdata = {31'b0, r_cfg.byte_order};
            REG_ALPHA_HANDLING: prdata = {30'b0, r_cfg.alpha_handling};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Datapath lanes
    pafc_rd_lane u_rd_lane (
        .i_clk        (i_clk),
        .i_cfg        (r_cfg),
        .i_pixel_word (i_pixel_word),
        .o_red        (rd_red),
        .o_green      (rd_green),
        .o_blue       (rd_blue),
        .o_alpha      (rd_alpha)
    );

    pafc_wr_lane u_wr_lane (
        .i_clk    (i_clk),
        .i_cfg    (r_cfg),
        .i_red    (i_red_in),
        .i_green  (i_green_in),
        .i_blue   (i_blue_in),
        .i_alpha  (i_alpha_in),
        .o_packed (wr_packed)
    );

    // Advance item valid and operation alongside the lanes
    assign n_vld = {r_vld[LANE_DEPTH-2:0], start & ~busy};
    assign n_op  = {r_op[LANE_DEPTH-2:0], i_operation};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_vld   <= n_vld;
            r_valid <= r_vld[LANE_DEPTH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;
    end

    // Select the finished lane and zero the other fields
    assign last_rd = (r_op[LANE_DEPTH-1] == OP_READ);

    always_ff @(posedge i_clk) begin
        r_packed <= last_rd ? '0 : wr_packed;
        r_red    <= last_rd ? rd_red   : '0;
        r_green  <= last_rd ? rd_green : '0;
        r_blue   <= last_rd ? rd_blue  : '0;
        r_alpha  <= last_rd ? rd_alpha : '0;
    end

    assign o_valid      = r_valid;
    assign o_packed_out = r_packed;
    assign o_red_out    = r_red;
    assign o_green_out  = r_green;
    assign o_blue_out   = r_blue;
    assign o_alpha_out  = r_alpha;

endmodule
